FILE: sv/tqg_pkg.sv
// shared types and constants for the grid q-learning step unit
// no dependencies

package tqg_pkg;

	localparam int MAP_BITS = 60;
	localparam logic [1:0] ST_OPEN   = 2'd0;
	localparam logic [1:0] ST_CLOSED = 2'd1;
	localparam logic [1:0] ST_GOAL   = 2'd2;
	localparam logic [1:0] ST_TRAP   = 2'd3;

	localparam logic [2:0] REG_MAP      = 3'd0;
	localparam logic [2:0] REG_GOAL     = 3'd1;
	localparam logic [2:0] REG_DISCOUNT = 3'd2;
	localparam logic [2:0] REG_EXPLORE  = 3'd3;
	localparam logic [2:0] REG_STRAIGHT = 3'd4;
	localparam logic [2:0] REG_RIGHT    = 3'd5;
	localparam logic [2:0] REG_TURNS    = 3'd6;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RDCUR,
		S_CHOOSE,
		S_RDNXT,
		S_MAXQ,
		S_MUL,
		S_DELTA,
		S_DIV,
		S_WRITE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic start;
		logic mode0;
		logic rd_cur;
		logic latch_cur;
		logic rd_nxt;
		logic latch_max;
		logic do_mul;
		logic do_delta;
		logic div_start;
		logic write;
		logic load_out;
		logic skip;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic div_done;
		logic active;
	} sts_t;

endpackage

FILE: sv/tqg_ram.sv
// generic single-port ram with registered read
// no dependencies

module tqg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

FILE: sv/tqg_div.sv
// serial restoring divider, signed dividend by unsigned divisor, truncates toward zero
// no dependencies

module tqg_div #(
	parameter int NW = 34,
	parameter int DW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output logic signed [NW-1:0] quo,
	output logic                 done
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] mag_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q, mag_q[NW-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[NW-2:0], 1'b0};
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

FILE: sv/tqg_datapath.sv
// datapath: config registers, agent state, tables, arithmetic and output word
// depends on tqg_pkg, tqg_ram, tqg_div

module tqg_datapath import tqg_pkg::*; #(
	parameter int GRID_ROWS = 6,
	parameter int GRID_COLS = 5,
	parameter int Q_BITS = 24,
	parameter int COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [MAP_BITS-1:0]  cfg_data,
	input  logic                 mode,
	input  logic [2:0]           start_row,
	input  logic [2:0]           start_col,
	input  logic [15:0]          explore_roll,
	input  logic [1:0]           random_direction,
	input  logic [15:0]          drift_roll,
	output logic [2:0]           position_row,
	output logic [2:0]           position_col,
	output logic [1:0]           chosen_direction,
	output logic [1:0]           taken_direction,
	output logic signed [8:0]    reward,
	output logic signed [23:0]   updated_q,
	output logic                 updated,
	output logic                 trial_done
);
	localparam int NCELLS = GRID_ROWS * GRID_COLS;
	localparam int CLW = $clog2(NCELLS);
	localparam int PW = Q_BITS + 17;
	localparam int DLW = Q_BITS + 3;
	localparam logic signed [Q_BITS-1:0] QMAX = {1'b0, {(Q_BITS-1){1'b1}}};
	localparam logic signed [Q_BITS-1:0] QMIN = {1'b1, {(Q_BITS-1){1'b0}}};

	logic [MAP_BITS-1:0] map_q;
	logic [7:0]  goal_q;
	logic [15:0] disc_q, expl_q, strt_q, rght_q;
	logic [6:0]  turns_q, tcnt_q;
	logic [2:0]  row_q, col_q, nr_q, nc_q;
	logic        active_q;
	logic [1:0]  chosen_q, taken_q, rdir_q;
	logic [15:0] eroll_q, droll_q;
	logic [2:0]  srow_q, scol_q;
	logic [CLW-1:0] clr_q;

	logic [4*Q_BITS-1:0] q_rd;
	logic [4*COUNT_BITS-1:0] c_rd;
	logic [4*Q_BITS-1:0] q_wd;
	logic [4*COUNT_BITS-1:0] c_wd;
	logic [CLW-1:0] raddr;
	logic ram_we;

	logic signed [Q_BITS-1:0] qcur_q, maxq_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic signed [PW-1:0] prod_s1;
	logic signed [DLW-1:0] delta_q;
	logic signed [DLW-1:0] quo;
	logic signed [8:0] r_q;
	logic signed [Q_BITS-1:0] nq_q;
	logic div_done;

	function automatic logic [1:0] status_of(input logic [MAP_BITS-1:0] m,
		input logic [2:0] r, input logic [2:0] c);
		int idx;
		idx = int'(r) * GRID_COLS + int'(c);
		if (idx * 2 + 1 >= MAP_BITS)
			return ST_OPEN;
		return m[idx*2 +: 2];
	endfunction

	function automatic logic signed [Q_BITS-1:0] qsel(input logic [4*Q_BITS-1:0] w,
		input logic [1:0] d);
		return w[d*Q_BITS +: Q_BITS];
	endfunction

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
			goal_q <= 8'd100;
			disc_q <= 16'd58982;
			expl_q <= 16'd3277;
			strt_q <= 16'd19661;
			rght_q <= 16'd9830;
			turns_q <= 7'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP: map_q <= cfg_data;
				REG_GOAL: goal_q <= cfg_data[7:0];
				REG_DISCOUNT: disc_q <= cfg_data[15:0];
				REG_EXPLORE: expl_q <= cfg_data[15:0];
				REG_STRAIGHT: strt_q <= cfg_data[15:0];
				REG_RIGHT: rght_q <= cfg_data[15:0];
				REG_TURNS: turns_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clear pass counter, one cell (four entries) a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.clr_step)
			clr_q <= clr_q + 1'b1;
	end

	assign sts = '{clr_done: (clr_q == CLW'(NCELLS - 1)), div_done: div_done,
		active: active_q};

	// one ram word per cell holds its four directions
	logic [2:0] arow, acol;
	always_comb begin
		arow = cmd.rd_nxt ? nr_q : row_q;
		acol = cmd.rd_nxt ? nc_q : col_q;
		raddr = CLW'(int'(arow) * GRID_COLS + int'(acol));
		if (cmd.clr_step)
			raddr = clr_q;
		ram_we = cmd.clr_step || cmd.write;
	end

	logic [4*Q_BITS-1:0] qcur_word_q;
	logic [4*COUNT_BITS-1:0] ccur_word_q;
	always_comb begin
		q_wd = qcur_word_q;
		c_wd = ccur_word_q;
		q_wd[chosen_q*Q_BITS +: Q_BITS] = nq_q;
		c_wd[chosen_q*COUNT_BITS +: COUNT_BITS] = cnt_q;
		if (cmd.clr_step) begin
			q_wd = '0;
			c_wd = '0;
		end
	end

	tqg_ram #(.WIDTH(4*Q_BITS), .DEPTH(NCELLS)) u_qram (
		.clk(clk), .we(ram_we), .addr(raddr), .wdata(q_wd), .rdata(q_rd));
	tqg_ram #(.WIDTH(4*COUNT_BITS), .DEPTH(NCELLS)) u_cram (
		.clk(clk), .we(ram_we), .addr(raddr), .wdata(c_wd), .rdata(c_rd));

	// greedy pick and drift
	logic [1:0] greedy, ch, tk, mx_d;
	logic [2:0] tr, tc;
	logic blk;
	always_comb begin
		greedy = DIR_N;
		for (int d = 1; d < 4; d++)
			if (qsel(q_rd, 2'(d)) > qsel(q_rd, greedy))
				greedy = 2'(d);
		ch = (eroll_q <= expl_q) ? rdir_q : greedy;
		if (droll_q >= strt_q)
			tk = ch;
		else if (droll_q > rght_q)
			tk = ch + 2'd3;
		else
			tk = ch + 2'd1;
		tr = row_q;
		tc = col_q;
		blk = 1'b0;
		unique case (tk)
			DIR_N: if (row_q == 3'd0) blk = 1'b1; else tr = row_q - 3'd1;
			DIR_E: if (int'(col_q) + 1 >= GRID_COLS) blk = 1'b1; else tc = col_q + 3'd1;
			DIR_S: if (int'(row_q) + 1 >= GRID_ROWS) blk = 1'b1; else tr = row_q + 3'd1;
			DIR_W: if (col_q == 3'd0) blk = 1'b1; else tc = col_q - 3'd1;
			default: ;
		endcase
		if (!blk && status_of(map_q, tr, tc) == ST_CLOSED)
			blk = 1'b1;
		if (blk) begin
			tr = row_q;
			tc = col_q;
		end
		mx_d = DIR_N;
		for (int d = 1; d < 4; d++)
			if (qsel(q_rd, 2'(d)) > qsel(q_rd, mx_d))
				mx_d = 2'(d);
	end

	logic [COUNT_BITS-1:0] cnt_old;
	assign cnt_old = c_rd[ch*COUNT_BITS +: COUNT_BITS];

	logic signed [DLW-1:0] nq_wide;
	assign nq_wide = DLW'(qcur_q) + quo;

	logic signed [PW-1:0] gmax;
	assign gmax = (prod_s1 + PW'(32768)) >>> 16;

	tqg_div #(.NW(DLW), .DW(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(delta_q), .den(cnt_q), .quo(quo), .done(div_done));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			srow_q <= start_row;
			scol_q <= start_col;
			eroll_q <= explore_roll;
			rdir_q <= random_direction;
			droll_q <= drift_roll;
		end
		if (cmd.latch_cur) begin
			chosen_q <= ch;
			taken_q <= tk;
			nr_q <= tr;
			nc_q <= tc;
			qcur_word_q <= q_rd;
			ccur_word_q <= c_rd;
			qcur_q <= qsel(q_rd, ch);
			cnt_q <= (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;
			r_q <= ((tk == DIR_N) ? -9'sd3 : (tk == DIR_S) ? -9'sd1 : -9'sd2) +
				((!blk && status_of(map_q, tr, tc) == ST_GOAL) ?
					$signed({1'b0, goal_q}) : 9'sd0);
		end
		if (cmd.latch_max)
			maxq_q <= qsel(q_rd, mx_d);
		if (cmd.do_mul)
			prod_s1 <= PW'(maxq_q) * $signed({1'b0, disc_q});
		if (cmd.do_delta)
			delta_q <= DLW'(r_q) * DLW'(256) + DLW'(gmax) - DLW'(qcur_q);
		if (div_done)
			nq_q <= (nq_wide > DLW'(QMAX)) ? QMAX :
				(nq_wide < DLW'(QMIN)) ? QMIN : nq_wide[Q_BITS-1:0];
	end

	// agent state and output word
	logic [2:0] sr, sc;
	logic [1:0] sst;
	logic [6:0] tnext;
	logic [1:0] nst;
	always_comb begin
		sr = (int'(srow_q) >= GRID_ROWS) ? 3'(GRID_ROWS - 1) : srow_q;
		sc = (int'(scol_q) >= GRID_COLS) ? 3'(GRID_COLS - 1) : scol_q;
		sst = status_of(map_q, sr, sc);
		tnext = tcnt_q + 7'd1;
		nst = status_of(map_q, nr_q, nc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			tcnt_q <= '0;
			active_q <= 1'b0;
			position_row <= '0;
			position_col <= '0;
			chosen_direction <= DIR_N;
			taken_direction <= DIR_N;
			reward <= '0;
			updated_q <= '0;
			updated <= 1'b0;
			trial_done <= 1'b0;
		end else if (cmd.load_out) begin
			position_row <= row_q;
			position_col <= col_q;
			chosen_direction <= DIR_N;
			taken_direction <= DIR_N;
			reward <= '0;
			updated_q <= '0;
			updated <= 1'b0;
			trial_done <= 1'b1;
			if (cmd.mode0) begin
				row_q <= sr;
				col_q <= sc;
				position_row <= sr;
				position_col <= sc;
				tcnt_q <= '0;
				active_q <= !(sst == ST_GOAL || sst == ST_TRAP);
				trial_done <= (sst == ST_GOAL || sst == ST_TRAP);
			end else if (!cmd.skip) begin
				row_q <= nr_q;
				col_q <= nc_q;
				position_row <= nr_q;
				position_col <= nc_q;
				tcnt_q <= tnext;
				chosen_direction <= chosen_q;
				taken_direction <= taken_q;
				reward <= r_q;
				updated_q <= 24'(nq_q);
				updated <= 1'b1;
				active_q <= !(nst == ST_GOAL || nst == ST_TRAP || tnext >= turns_q);
				trial_done <= (nst == ST_GOAL || nst == ST_TRAP || tnext >= turns_q);
			end
		end
	end
endmodule

FILE: sv/tqg_ctrl.sv
// controller state machine: clear pass, turn sequencing and output handshake
// depends on tqg_pkg

module tqg_ctrl import tqg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_mode,
	input  logic out_stall,
	input  sts_t sts,
	output logic in_stall,
	output logic out_valid,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic ov_q, ov_d;
	logic mode0_q, skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
				if (in_valid)
					state_d = (!in_mode && 1'b1) ? S_OUT : (sts.active ? S_RDCUR : S_OUT);
			end
			S_RDCUR: begin
				cmd.rd_cur = 1'b1;
				state_d = S_CHOOSE;
			end
			S_CHOOSE: begin
				cmd.latch_cur = 1'b1;
				state_d = S_RDNXT;
			end
			S_RDNXT: begin
				cmd.rd_nxt = 1'b1;
				state_d = S_MAXQ;
			end
			S_MAXQ: begin
				cmd.latch_max = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.do_mul = 1'b1;
				state_d = S_DELTA;
			end
			S_DELTA: begin
				cmd.do_delta = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_start = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (sts.div_done)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.load_out = 1'b1;
					cmd.mode0 = mode0_q;
					cmd.skip = skip_q;
					cmd.write = !mode0_q && !skip_q;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode0_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (state_q == S_IDLE && in_valid) begin
			mode0_q <= !in_mode;
			skip_q <= in_mode && !sts.active;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == S_WRITE)
		else $error("divider start outside sequence");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> !cmd.clr_step)
		else $error("write during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> in_stall)
		else $error("input taken during clear");
endmodule

FILE: sv/tabular_q_learning_grid_step_unit.sv
// top level of the grid q-learning step unit
// depends on tqg_pkg, tqg_ctrl, tqg_datapath
//
// input channel in_valid/in_stall carries one word per item: mode 0 starts a
// trial at start_row/start_col, mode 1 takes one turn using the rolls.
// output channel out_valid/out_stall returns one word per item.
// configuration: cfg_we, cfg_index, cfg_data, to be written only while idle; not enforced.
// after reset a clearing pass zeroes the q and visit-count memories (one cell
// word a cycle); input is stalled meanwhile.
// a start item or a turn with no trial running goes from S_IDLE to S_OUT, which
// registers its result once the output register is free, and then back to
// S_IDLE for the next word; a learning turn steps through S_RDCUR, S_CHOOSE,
// S_RDNXT, S_MAXQ, S_MUL, S_DELTA and S_DIV, then waits in S_WRITE on the
// serial divider (delta / visit count, one quotient bit a cycle) before S_OUT.
// one item is worked at a time; while a result waits under out_stall one more
// word may be taken and worked, then it holds in its last step and input
// stalls until the output register frees.

module tabular_q_learning_grid_step_unit import tqg_pkg::*; #(
	parameter int GRID_ROWS = 6,
	parameter int GRID_COLS = 5,
	parameter int Q_BITS = 24,
	parameter int COUNT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                mode,
	input  logic [2:0]          start_row,
	input  logic [2:0]          start_col,
	input  logic [15:0]         explore_roll,
	input  logic [1:0]          random_direction,
	input  logic [15:0]         drift_roll,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          position_row,
	output logic [2:0]          position_col,
	output logic [1:0]          chosen_direction,
	output logic [1:0]          taken_direction,
	output logic signed [8:0]   reward,
	output logic signed [23:0]  updated_q,
	output logic                updated,
	output logic                trial_done,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [MAP_BITS-1:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;

	tqg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_mode(mode),
		.out_stall(out_stall), .sts(sts),
		.in_stall(in_stall), .out_valid(out_valid), .cmd(cmd));

	tqg_datapath #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS),
		.Q_BITS(Q_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mode(mode), .start_row(start_row), .start_col(start_col),
		.explore_roll(explore_roll), .random_direction(random_direction),
		.drift_roll(drift_roll), .position_row(position_row),
		.position_col(position_col), .chosen_direction(chosen_direction),
		.taken_direction(taken_direction), .reward(reward), .updated_q(updated_q),
		.updated(updated), .trial_done(trial_done));
endmodule
